// ----- design/ptu_pkg.sv -----
// Package with the types, action codes and level arithmetic of the pheromone table.
`timescale 1ns / 1ps
`default_nettype none

package ptu_pkg;

   typedef logic [23:0] level_type;
   typedef logic [4:0]  vertex_type;
   typedef logic [1:0]  action_type;

   localparam action_type ACT_RESET     = 2'd0;
   localparam action_type ACT_EVAPORATE = 2'd1;
   localparam action_type ACT_DEPOSIT   = 2'd2;
   localparam action_type ACT_READ      = 2'd3;

   localparam level_type LEVEL_ONE   = 24'h000100;
   localparam level_type LEVEL_RESET = 24'h006400;
   localparam level_type LEVEL_MAX   = 24'hFFFFFF;

   // An entry loses the amount but never falls below one, and an entry at or
   // below one comes out as exactly one.
   function automatic level_type evap_level(input level_type entry, input level_type amount);
      logic [24:0] diff;
      level_type   result;
      diff = {1'b0, entry} - {1'b0, amount};
      if (!diff[24] && diff[23:0] >= LEVEL_ONE) begin
         result = diff[23:0];
      end else begin
         result = LEVEL_ONE;
      end
      return result;
   endfunction

   // Adds the deposit and saturates at the largest level.
   function automatic level_type deposit_level(input level_type entry, input level_type amount);
      logic [24:0] sum;
      level_type   result;
      sum = {1'b0, entry} + {1'b0, amount};
      if (sum[24]) begin
         result = LEVEL_MAX;
      end else begin
         result = sum[23:0];
      end
      return result;
   endfunction

endpackage

`default_nettype wire

// ----- design/pheromone_table_update.sv -----
// Pheromone table: one memory of edge levels with read, deposit and sweep control.
`timescale 1ns / 1ps
`default_nettype none

// Keeps a VERTICES by VERTICES table of Q16.8 edge levels in one synchronous
// memory with a single read port and a single write port. Every transfer on the
// request side gives one response. A read or a deposit does the memory read
// and then the update and response. Reset-to-100 writes one entry per cycle;
// evaporate reads, modifies and writes one entry per cycle. After the reset
// input the block runs a clearing pass over all VERTICES*VERTICES entries,
// with req_stall high, before it takes the first request. A finished response
// sits in an output register, so the next request is taken while it waits.
module pheromone_table_update #(
   parameter int VERTICES = 32
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  wire [1:0]           req_action,
   input  wire [23:0]          req_strength,
   input  wire [4:0]           req_vertex,
   input  wire                 req_path_first,
   input  wire [4:0]           req_query_row,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output logic [23:0]         rsp_level
);

   localparam int ENTRIES = VERTICES * VERTICES;
   localparam int AW      = $clog2(ENTRIES);
   localparam int CW      = $clog2(ENTRIES + 1);
   localparam logic [CW-1:0] CNT_LAST = CW'(ENTRIES - 1);
   localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_FILL   = 3'd1;
   localparam logic [2:0] S_EVAP   = 3'd2;
   localparam logic [2:0] S_ACCESS = 3'd3;
   localparam logic [2:0] S_REPLY  = 3'd4;

   ptu_pkg::level_type mem [ENTRIES];
   ptu_pkg::level_type rdata_ff;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                owed_ff, owed_in;
   logic                pipe_valid_ff, pipe_valid_in;
   logic [AW-1:0]       pipe_addr_ff, pipe_addr_in;
   ptu_pkg::vertex_type prev_ff, prev_in;
   logic                hit_ff, hit_in;
   logic [AW-1:0]       addr_ff, addr_in;
   ptu_pkg::level_type  strength_ff, strength_in;
   ptu_pkg::action_type action_ff, action_in;
   logic                rsp_valid_ff, rsp_valid_in;
   ptu_pkg::level_type  rsp_level_ff, rsp_level_in;

   logic                req_accept;
   logic                out_free;
   logic                mem_we;
   logic [AW-1:0]       mem_waddr;
   ptu_pkg::level_type  mem_wdata;
   logic                mem_re;
   logic [AW-1:0]       mem_raddr;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_level  = rsp_level_ff;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      owed_in       = owed_ff;
      pipe_valid_in = 1'b0;
      pipe_addr_in  = pipe_addr_ff;
      prev_in       = prev_ff;
      hit_in        = hit_ff;
      addr_in       = addr_ff;
      strength_in   = strength_ff;
      action_in     = action_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_level_in  = rsp_level_ff;
      mem_we        = 1'b0;
      mem_waddr     = pipe_addr_ff;
      mem_wdata     = ptu_pkg::evap_level(rdata_ff, strength_ff);
      mem_re        = 1'b0;
      mem_raddr     = addr_ff;

      // The evaporate sweep writes back each entry in the cycle after its read.
      if (pipe_valid_ff) begin
         mem_we = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               action_in   = req_action;
               strength_in = req_strength;
               cnt_in      = '0;
               unique case (req_action)
                  ptu_pkg::ACT_RESET: begin
                     owed_in  = 1'b1;
                     state_in = S_FILL;
                  end
                  ptu_pkg::ACT_EVAPORATE: begin
                     state_in = S_EVAP;
                  end
                  ptu_pkg::ACT_DEPOSIT: begin
                     hit_in = !req_path_first && (32'(prev_ff) < VERTICES)
                              && (32'(req_vertex) < VERTICES);
                     addr_in = AW'(32'(prev_ff) * 32'(VERTICES) + 32'(req_vertex));
                     prev_in  = req_vertex;
                     state_in = S_ACCESS;
                  end
                  ptu_pkg::ACT_READ: begin
                     hit_in = (32'(req_query_row) < VERTICES)
                              && (32'(req_vertex) < VERTICES);
                     addr_in = AW'(32'(req_query_row) * 32'(VERTICES)
                                   + 32'(req_vertex));
                     state_in = S_ACCESS;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
               mem_re    = 1'b1;
               mem_raddr = addr_in;
            end
         end
         S_FILL: begin
            mem_we    = 1'b1;
            mem_waddr = cnt_ff[AW-1:0];
            mem_wdata = ptu_pkg::LEVEL_RESET;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               state_in = owed_ff ? S_REPLY : S_IDLE;
            end
         end
         S_EVAP: begin
            if (cnt_ff != CNT_END) begin
               mem_re        = 1'b1;
               mem_raddr     = cnt_ff[AW-1:0];
               pipe_valid_in = 1'b1;
               pipe_addr_in  = cnt_ff[AW-1:0];
               cnt_in        = cnt_ff + 1'b1;
            end else begin
               state_in = S_REPLY;
            end
         end
         S_ACCESS: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = '0;
               if (hit_ff) begin
                  if (action_ff == ptu_pkg::ACT_DEPOSIT) begin
                     mem_we       = 1'b1;
                     mem_waddr    = addr_ff;
                     mem_wdata    = ptu_pkg::deposit_level(rdata_ff, strength_ff);
                     rsp_level_in = mem_wdata;
                  end else begin
                     rsp_level_in = rdata_ff;
                  end
               end
               state_in = S_IDLE;
            end
         end
         S_REPLY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_level_in = '0;
               owed_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_FILL;
         cnt_ff        <= '0;
         owed_ff       <= 1'b0;
         pipe_valid_ff <= 1'b0;
         prev_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         owed_ff       <= owed_in;
         pipe_valid_ff <= pipe_valid_in;
         prev_ff       <= prev_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pipe_addr_ff <= pipe_addr_in;
      hit_ff       <= hit_in;
      addr_ff      <= addr_in;
      strength_ff  <= strength_in;
      action_ff    <= action_in;
      rsp_level_ff <= rsp_level_in;
   end

   // No entry is written while the block waits for a request.
   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !mem_we)
      else $error("memory written while idle");

   // An evaporate transfer starts its sweep at the first entry.
   a_evap_start: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_action == ptu_pkg::ACT_EVAPORATE)
      |=> (state_ff == S_EVAP && cnt_ff == '0))
      else $error("evaporate sweep did not start at entry zero");

   // A write-back of the sweep is only pending during or just after the sweep.
   a_pipe_in_sweep: assert property (@(posedge clock) disable iff (reset)
      pipe_valid_ff |-> (state_ff == S_EVAP || state_ff == S_REPLY))
      else $error("sweep write-back outside the sweep");

   // A single-entry access completes as soon as the output register is free.
   a_access_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ACCESS && out_free) |=> (state_ff == S_IDLE && rsp_valid_ff))
      else $error("entry access did not complete");

endmodule

`default_nettype wire
